@@ rtl/als_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// als_pkg
// Shared types and codes of the array list store: request codes, result
// status codes, controller states and the broadcast control of the cell row.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned StatusW = 3;

  typedef enum logic [FuncW-1:0] {
    FnPush   = 2'd0,
    FnRemove = 2'd1,
    FnPop    = 2'd2,
    FnRead   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StNotFound = 3'd2,
    StEmpty    = 3'd3,
    StRange    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StateIdle  = 3'b001,
    StateSweep = 3'b010,
    StateShift = 3'b100
  } state_e;

  typedef struct packed {
    logic push;
    logic start;
    logic sweep;
    logic found;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage : als_pkg
`default_nettype wire

@@ rtl/als_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// als_cell
// One slot of the list. Holds one entry, takes a pushed value when the fill
// count points at it, passes the remove token to its upper neighbor, takes
// its upper neighbor's entry once the match has been seen, and carries a
// read word down toward slot zero.
// ----------------------------------------------------------------------------
module als_cell #(
  parameter int unsigned CntW = 7,
  parameter int unsigned Pos  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  als_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CntW-1:0]           count_i,
  input  logic [als_pkg::DataW-1:0] push_value_i,
  input  logic [als_pkg::DataW-1:0] match_value_i,
  input  logic                      tok_i,
  input  logic [als_pkg::DataW-1:0] up_entry_i,
  input  logic [als_pkg::DataW-1:0] up_pipe_i,
  output logic                      tok_o,
  output logic                      hit_o,
  output logic [als_pkg::DataW-1:0] entry_o,
  output logic [als_pkg::DataW-1:0] pipe_o
);
  import als_pkg::*;

  logic             tok_q;
  logic [DataW-1:0] entry_q;
  logic [DataW-1:0] pipe_q;
  logic             push_we;
  logic             shift_we;

  assign hit_o    = tok_q && !ctrl_i.found && (entry_q == match_value_i);
  assign push_we  = ctrl_i.push && (count_i == CntW'(Pos));
  assign shift_we = ctrl_i.sweep && tok_q && (ctrl_i.found || hit_o);

  // start plants the token in slot zero only and drops any token left over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= (tok_i && ctrl_i.sweep) || (ctrl_i.start && (Pos == 0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      entry_q <= push_value_i;
    end else if (shift_we) begin
      entry_q <= up_entry_i;
    end
    if (ctrl_i.load) begin
      pipe_q <= entry_q;
    end else if (ctrl_i.shift) begin
      pipe_q <= up_pipe_i;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;
  assign pipe_o  = pipe_q;

endmodule : als_cell
`default_nettype wire

@@ rtl/array_list_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_store
// Bounded ordered list of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// Push and pop finish in the cycle the request beat is taken; the result beat
// is offered on the next cycle. On a remove from a list of N entries, a token
// walks the row one cell per cycle, and every cell at or past the first match
// takes its upper neighbor's entry as the token passes. A remove that finds no
// match still walks all N entries. On a read at index K, the row copies its
// entries into a read chain that moves down one cell per cycle until entry K
// reaches cell zero. Full, empty, out of range and a remove on an empty list
// finish at once. A new request is taken only when the controller is idle and
// the result register is empty or being drained.
module array_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [als_pkg::FuncW-1:0]           func_i,
  input  logic signed [als_pkg::DataW-1:0]    value_i,
  input  logic [als_pkg::IndexW-1:0]          index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [als_pkg::DataW-1:0]    read_value_o,
  output logic [als_pkg::StatusW-1:0]         status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       count_o
);
  import als_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]  idx_q, idx_d;
  logic [DataW-1:0] val_q, val_d;
  logic             found_q, found_d;

  logic             out_valid_q;
  logic [DataW-1:0] rv_q;
  status_e          st_q;
  logic [CntW-1:0]  oc_q;

  logic             set_out;
  logic [DataW-1:0] res_rv;
  status_e          res_st;

  cell_ctrl_t       ctrl;
  logic             accept;
  logic             out_free;
  logic             found_now;
  logic             last_pos;

  logic [CAPACITY-1:0]            tok;
  logic [CAPACITY-1:0]            hit;
  logic [CAPACITY-1:0][DataW-1:0] entry;
  logic [CAPACITY-1:0][DataW-1:0] pipe;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StateIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign found_now  = found_q || (|hit);
  assign last_pos   = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    val_d      = val_q;
    found_d    = found_q;
    set_out    = 1'b0;
    res_rv     = '0;
    res_st     = StOk;
    ctrl       = '0;
    ctrl.found = found_q;
    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          unique case (func_e'(func_i))
            FnPush: begin
              set_out = 1'b1;
              if (cnt_q >= CntW'(CAPACITY)) begin
                res_st = StFull;
              end else begin
                ctrl.push = 1'b1;
                cnt_d     = cnt_q + CntW'(1);
              end
            end
            FnRemove: begin
              if (cnt_q == '0) begin
                set_out = 1'b1;
                res_st  = StNotFound;
              end else begin
                ctrl.start = 1'b1;
                val_d      = value_i;
                idx_d      = '0;
                found_d    = 1'b0;
                state_d    = StateSweep;
              end
            end
            FnPop: begin
              set_out = 1'b1;
              if (cnt_q == '0) begin
                res_st = StEmpty;
              end else begin
                cnt_d = cnt_q - CntW'(1);
              end
            end
            FnRead: begin
              if (CmpW'(index_i) >= CmpW'(cnt_q)) begin
                set_out = 1'b1;
                res_st  = StRange;
              end else begin
                ctrl.load = 1'b1;
                idx_d     = index_i[PosW-1:0];
                state_d   = StateShift;
              end
            end
            default: begin
              set_out = 1'b1;
            end
          endcase
        end
      end
      StateSweep: begin
        ctrl.sweep = 1'b1;
        found_d    = found_now;
        if (last_pos) begin
          set_out = 1'b1;
          state_d = StateIdle;
          if (found_now) begin
            cnt_d = cnt_q - CntW'(1);
          end else begin
            res_st = StNotFound;
          end
        end else begin
          idx_d = idx_q + PosW'(1);
        end
      end
      StateShift: begin
        if (idx_q == '0) begin
          set_out = 1'b1;
          res_rv  = pipe[0];
          state_d = StateIdle;
        end else begin
          ctrl.shift = 1'b1;
          idx_d      = idx_q - PosW'(1);
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      if (set_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (set_out) begin
      rv_q <= res_rv;
      st_q <= res_st;
      oc_q <= cnt_d;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             tok_in;
    logic [DataW-1:0] up_entry;
    logic [DataW-1:0] up_pipe;

    if (g == 0) begin : g_first
      assign tok_in = ctrl.start;
    end else begin : g_next
      assign tok_in = tok[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign up_entry = entry[g];
      assign up_pipe  = pipe[g];
    end else begin : g_inner
      assign up_entry = entry[g+1];
      assign up_pipe  = pipe[g+1];
    end

    als_cell #(
      .CntW (CntW),
      .Pos  (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .count_i       (cnt_q),
      .push_value_i  (value_i),
      .match_value_i (val_q),
      .tok_i         (tok_in),
      .up_entry_i    (up_entry),
      .up_pipe_i     (up_pipe),
      .tok_o         (tok[g]),
      .hit_o         (hit[g]),
      .entry_o       (entry[g]),
      .pipe_o        (pipe[g])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;
  assign count_o      = oc_q;

endmodule : array_list_store
`default_nettype wire
